// ===== rtl/core/ffba_pkg.sv =====
`timescale 1ns / 1ps
package ffba_pkg;

   localparam logic [7:0] POOL_BYTES_MAX = 8'd255;
   localparam logic [7:0] POOL_RESET = 8'd80;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NO_MEMORY = 2'd1;
   localparam logic [1:0] ST_BAD_OFFSET = 2'd2;

   typedef struct packed {
      logic       action;
      logic [7:0] request_bytes;
      logic [7:0] release_offset;
   } req_type;

   typedef struct packed {
      logic [7:0] block_offset;
      logic [1:0] status;
      logic [7:0] bytes_taken;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic       free;
      logic [7:0] start;
      logic [7:0] length;
   } cell_data_type;

   typedef struct packed {
      logic [7:0] where;
      logic [7:0] rem_start;
      logic [7:0] rem_length;
      logic       left;
      logic       right;
      logic       wr_rem;
   } plan_type;

   typedef struct packed {
      logic       eval;
      logic       apply;
      logic [7:0] need;
      logic [7:0] offset;
      logic       full;
      logic       take_tab;
      logic       take_tail;
      logic       rel_go;
      logic [7:0] tail;
      plan_type   plan;
   } ctrl_type;

endpackage

// ===== rtl/core/ffba_cell.sv =====
`timescale 1ns / 1ps
module ffba_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  ffba_pkg::ctrl_type     ctrl,
   input  ffba_pkg::cell_data_type prev,
   input  ffba_pkg::cell_data_type next1,
   input  ffba_pkg::cell_data_type next2,
   input  logic                   sel_self,
   input  logic                   sel_prev,
   input  logic                   ge_self,
   output ffba_pkg::cell_data_type data,
   output logic                   cand,
   output logic                   match,
   output ffba_pkg::plan_type     plan
);
   import ffba_pkg::*;

   cell_data_type data_ff, data_in;
   logic          cand_ff, cand_in;
   logic          match_ff, match_in;
   plan_type      plan_ff, plan_in;
   logic          nf, f2;
   logic [8:0]    avail, rem;

   always_comb begin
      nf = next1.valid & next1.free;
      f2 = next2.valid & next2.free;
      avail = {1'b0, data_ff.length} + (nf ? {1'b0, next1.length} : 9'd0);
      rem = avail - {1'b0, ctrl.need};
      cand_in = data_ff.valid & data_ff.free & (avail >= {1'b0, ctrl.need})
         & (ctrl.need != 8'd0)
         & !(!nf && (data_ff.length > ctrl.need) && ctrl.full);
      match_in = data_ff.valid & (data_ff.start == ctrl.offset);
      plan_in.where = data_ff.start;
      plan_in.rem_start = data_ff.start + ctrl.need;
      plan_in.rem_length = rem[7:0];
      plan_in.left = nf & (f2 | (rem == 9'd0));
      plan_in.right = !nf & (rem != 9'd0);
      plan_in.wr_rem = (rem != 9'd0) & !(nf & f2);
   end

   always_comb begin
      data_in = data_ff;
      if (ctrl.take_tab) begin
         if (sel_self) begin
            data_in.length = ctrl.need;
            data_in.free = 1'b0;
         end else if (sel_prev) begin
            if (ctrl.plan.wr_rem) begin
               data_in = '{valid: 1'b1, free: 1'b1, start: ctrl.plan.rem_start,
                           length: ctrl.plan.rem_length};
            end else if (ctrl.plan.left) begin
               data_in = '{valid: next1.valid, free: next1.free,
                           start: ctrl.plan.rem_start,
                           length: next1.length + ctrl.plan.rem_length};
            end
         end else if (ge_self) begin
            if (ctrl.plan.left) begin
               data_in = next1;
            end else if (ctrl.plan.right) begin
               data_in = prev;
            end
         end
      end
      if (ctrl.take_tail && !data_ff.valid && prev.valid) begin
         data_in = '{valid: 1'b1, free: 1'b0, start: ctrl.tail, length: ctrl.need};
      end
      if (ctrl.rel_go && match_ff) begin
         data_in.free = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else if (ctrl.apply) begin
         data_ff.valid <= data_in.valid;
      end
      if (ctrl.apply) begin
         data_ff.free <= data_in.free;
         data_ff.start <= data_in.start;
         data_ff.length <= data_in.length;
      end
      if (ctrl.eval) begin
         cand_ff <= cand_in;
         match_ff <= match_in;
         plan_ff <= plan_in;
      end
   end

   assign data = data_ff;
   assign cand = cand_ff;
   assign match = match_ff;
   assign plan = plan_ff;

endmodule

// ===== rtl/core/first_fit_block_allocator_unit.sv =====
`timescale 1ns / 1ps
// First-fit byte-pool allocator over a row of MAX_BLOCKS table cells kept in address order.
// A request is taken when start is high and busy is low; after the EVAL, PICK and APPLY
// states its result appears on rsp_item for one cycle with rsp_valid high, and it must be
// caught then, since the receiver cannot stall the block. These states make up the table
// pass: all cells test the request at once, a find-first picks the first fitting cell,
// then every cell merges, splits or shifts with its neighbors in one step. Busy stays
// high from acceptance until the result cycle, so one request is in flight at a time.
module first_fit_block_allocator_unit #(
   parameter int MAX_BLOCKS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ffba_pkg::req_type req_item,
   output logic              rsp_valid,
   output ffba_pkg::rsp_type rsp_item,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data
);
   import ffba_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_EVAL  = 4'b0010,
      S_PICK  = 4'b0100,
      S_APPLY = 4'b1000
   } state_type;

   state_type       state_ff, state_in;
   req_type         req_ff;
   logic [7:0]      pool_ff, tail_ff, taken_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_ff, rsp_in;
   logic [MAX_BLOCKS-1:0] cand_vec, match_vec, sel_ff, ge_ff, sel_in, ge_in;
   plan_type        plan_ff, plan_in;
   logic            any_ff;
   logic [7:0]      rel_len_ff, rel_len_in;
   logic            rel_hit_ff, rel_free_ff, rel_free_in;
   cell_data_type   data_a [MAX_BLOCKS];
   plan_type        plan_a [MAX_BLOCKS];
   ctrl_type        ctrl;
   logic [7:0]      limit;
   logic [8:0]      tail_sum;
   logic            full, is_alloc, tail_ok;
   logic [7:0]      tail_in, taken_in;

   assign full = data_a[MAX_BLOCKS-1].valid;
   assign limit = (pool_ff < POOL_BYTES_MAX) ? pool_ff : POOL_BYTES_MAX;
   assign tail_sum = {1'b0, tail_ff} + {1'b0, req_ff.request_bytes};
   assign is_alloc = (req_ff.action == ACT_ALLOC);
   assign tail_ok = (req_ff.request_bytes != 8'd0) && !any_ff && !full
      && (tail_sum <= {1'b0, limit});

   always_comb begin
      ctrl.eval = (state_ff == S_EVAL);
      ctrl.apply = (state_ff == S_APPLY);
      ctrl.need = req_ff.request_bytes;
      ctrl.offset = req_ff.release_offset;
      ctrl.full = full;
      ctrl.take_tab = ctrl.apply && is_alloc && any_ff;
      ctrl.take_tail = ctrl.apply && is_alloc && tail_ok;
      ctrl.rel_go = ctrl.apply && !is_alloc && rel_hit_ff && !rel_free_ff;
      ctrl.tail = tail_ff;
      ctrl.plan = plan_ff;
   end

   for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
      cell_data_type prev_d, next1_d, next2_d;
      logic          sel_p;
      if (k == 0) begin : g_first
         assign prev_d = '{valid: 1'b1, free: 1'b0, start: 8'd0, length: 8'd0};
         assign sel_p = 1'b0;
      end else begin : g_mid
         assign prev_d = data_a[k-1];
         assign sel_p = sel_ff[k-1];
      end
      if (k + 1 < MAX_BLOCKS) begin : g_n1
         assign next1_d = data_a[k+1];
      end else begin : g_n1z
         assign next1_d = '0;
      end
      if (k + 2 < MAX_BLOCKS) begin : g_n2
         assign next2_d = data_a[k+2];
      end else begin : g_n2z
         assign next2_d = '0;
      end
      ffba_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .prev     (prev_d),
         .next1    (next1_d),
         .next2    (next2_d),
         .sel_self (sel_ff[k]),
         .sel_prev (sel_p),
         .ge_self  (ge_ff[k]),
         .data     (data_a[k]),
         .cand     (cand_vec[k]),
         .match    (match_vec[k]),
         .plan     (plan_a[k])
      );
   end

   always_comb begin
      sel_in = cand_vec & (-cand_vec);
      ge_in = cand_vec | (-cand_vec);
      plan_in = '0;
      rel_len_in = '0;
      rel_free_in = 1'b0;
      for (int k = 0; k < MAX_BLOCKS; k++) begin
         plan_in = plan_in | (sel_in[k] ? plan_a[k] : '0);
         rel_len_in = rel_len_in | (match_vec[k] ? data_a[k].length : 8'd0);
         rel_free_in = rel_free_in | (match_vec[k] & data_a[k].free);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_EVAL;
         end
         S_EVAL:  state_in = S_PICK;
         S_PICK:  state_in = S_APPLY;
         S_APPLY: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_in = '{block_offset: 8'd0, status: ST_OK, bytes_taken: taken_ff};
      tail_in = tail_ff;
      taken_in = taken_ff;
      if (is_alloc) begin
         if (req_ff.request_bytes != 8'd0 && any_ff) begin
            rsp_in.block_offset = plan_ff.where;
            taken_in = taken_ff + req_ff.request_bytes;
         end else if (tail_ok) begin
            rsp_in.block_offset = tail_ff;
            tail_in = tail_sum[7:0];
            taken_in = taken_ff + req_ff.request_bytes;
         end else begin
            rsp_in.status = ST_NO_MEMORY;
         end
      end else if (rel_hit_ff && !rel_free_ff) begin
         taken_in = taken_ff - rel_len_ff;
      end else begin
         rsp_in.status = ST_BAD_OFFSET;
      end
      rsp_in.bytes_taken = taken_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pool_ff <= POOL_RESET;
         tail_ff <= 8'd0;
         taken_ff <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= (state_ff == S_APPLY);
         if (csr_wr_en) pool_ff <= csr_wr_data;
         if (state_ff == S_APPLY) begin
            tail_ff <= tail_in;
            taken_ff <= taken_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) req_ff <= req_item;
      if (state_ff == S_PICK) begin
         sel_ff <= sel_in;
         ge_ff <= ge_in;
         plan_ff <= plan_in;
         any_ff <= |cand_vec;
         rel_len_ff <= rel_len_in;
         rel_hit_ff <= |match_vec;
         rel_free_ff <= rel_free_in;
      end
      if (state_ff == S_APPLY) rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

   a_rsp_after_apply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_APPLY))
      else $error("result without table update");
   a_sel_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY) |-> $onehot0(sel_ff))
      else $error("more than one cell chosen");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transfer not held");
   a_tab_tail_excl: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.take_tab && ctrl.take_tail))
      else $error("table and tail grant together");

endmodule
